// ----- hdl/i8q_pkg.sv -----
// ----------------------------------------------------------------------------
// i8q_pkg: shared types and constants of the int8 abs-max quantizer
// Holds the item selector codes, the result kind and status codes and the
// fixed single-precision constants used by the quantizer datapath.
// ----------------------------------------------------------------------------
package i8q_pkg;

   // Selector carried on the input channel.
   typedef enum logic [1:0] {
      MODE_CLEAR    = 2'd0,
      MODE_MEASURE  = 2'd1,
      MODE_REPORT   = 2'd2,
      MODE_QUANTIZE = 2'd3
   } mode_type;

   // Kind of result word.
   typedef enum logic {
      KIND_SCALE = 1'b0,
      KIND_CODE  = 1'b1
   } kind_type;

   // Status of a result word.
   typedef enum logic {
      STATUS_OK       = 1'b0,
      STATUS_NO_SCALE = 1'b1
   } status_type;

   // Single 1e-9, the value the running maximum restarts from.
   localparam logic [31:0] MAX_RESET_BITS = 32'h3089_705F;
   // Single +infinity; magnitudes above it are NaN.
   localparam logic [31:0] POS_INF_BITS   = 32'h7F80_0000;
   // 127.0 is 1.984375 * 2^6: its full 24-bit mantissa and biased exponent.
   localparam logic [23:0] DIV127_MANT    = 24'hFE_0000;
   localparam logic [7:0]  DIV127_EXP     = 8'd133;
   localparam logic [7:0]  EXP_BIAS       = 8'd127;
   // Quotient bits produced by the mantissa divider: one integer bit,
   // 24 fraction bits for the significand and one guard bit.
   localparam int          DIV_STEPS      = 26;
   localparam logic [7:0]  CODE_LIMIT     = 8'd127;

endpackage

// ----- hdl/int8_absmax_quantizer.sv -----
// ----------------------------------------------------------------------------
// int8_absmax_quantizer: symmetric per-tensor int8 quantizer
// Tracks the largest magnitude seen, derives scale = max / 127 and turns
// single-precision values into signed codes from -127 to 127.
// ----------------------------------------------------------------------------
// A user sends words whose tuser selects the operation: clear restarts the
// running maximum at 1e-9, measure folds in the magnitude of tdata, report
// latches and returns scale = max / 127 rounded to nearest even, and quantize
// returns tdata / scale, rounded half away from zero and saturated to
// +/-127. Clear and measure produce no result. Report and quantize produce
// one result word each. Both run through one restoring mantissa divider
// that resolves one quotient bit per cycle, so an item that needs a
// division passes through accept, 26 divider steps, rounding and the
// hand-off to the output register; a quantize whose code is known from the
// exponents alone, or one issued before any report, skips the divider.
// The block accepts no word while an item is in work. The result sits in an
// output register, so a new word is accepted while a finished result still
// waits for rsp_tready. A quantize before any report returns code 0 with
// status set.
// ----------------------------------------------------------------------------
module int8_absmax_quantizer (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] scale_bits, [39:32] code, [40] status
   output logic        rsp_tuser    // [0] kind
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_RND,
      ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] scale_ff, scale_in;
   logic        scale_valid_ff, scale_valid_in;
   logic        is_rep_ff, is_rep_in;
   logic        neg_ff, neg_in;
   logic [9:0]  exp_ff, exp_in;
   logic [23:0] divisor_ff, divisor_in;
   logic [24:0] rem_ff, rem_in;
   logic [25:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        pend_kind_ff, pend_kind_in;
   logic [7:0]  pend_code_ff, pend_code_in;
   logic        pend_status_ff, pend_status_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_scale_ff, rsp_scale_in;
   logic [7:0]  rsp_code_ff, rsp_code_in;
   logic        rsp_status_ff, rsp_status_in;

   // Input decode.
   logic [31:0] in_mag;
   logic [7:0]  in_exp;
   logic        in_nan, in_inf;
   logic [9:0]  exp_diff;
   logic [7:0]  sat_code;

   // Shared subtract and compare of the divider.
   logic        div_ge;
   logic [24:0] div_sub;

   // Rounding of the quotient.
   logic        q_top, q_guard, q_sticky, q_inc;
   logic [23:0] q_sig, q_mant;
   logic [24:0] q_sum;
   logic [9:0]  q_exp_adj, q_exp;
   logic [9:0]  q_shift_w;
   logic [23:0] q_shifted;
   logic [7:0]  q_mag;
   logic [8:0]  q_rnd;
   logic [7:0]  q_code;

   always_comb begin
      in_mag   = {1'b0, req_tdata[30:0]};
      in_exp   = req_tdata[30:23];
      in_nan   = in_mag > i8q_pkg::POS_INF_BITS;
      in_inf   = in_mag == i8q_pkg::POS_INF_BITS;
      exp_diff = {2'b00, in_exp} - {2'b00, scale_ff[30:23]};
      sat_code = req_tdata[31] ? (8'd0 - i8q_pkg::CODE_LIMIT) : i8q_pkg::CODE_LIMIT;
   end

   always_comb begin
      div_ge  = rem_ff >= {1'b0, divisor_ff};
      div_sub = rem_ff - {1'b0, divisor_ff};
   end

   // The quotient holds one integer bit and 25 fraction bits of the mantissa
   // ratio; the remainder supplies the sticky bit.
   always_comb begin
      q_top     = quo_ff[25];
      q_sig     = q_top ? quo_ff[25:2] : quo_ff[24:1];
      q_guard   = q_top ? quo_ff[1] : quo_ff[0];
      q_sticky  = (q_top & quo_ff[0]) | (rem_ff != 25'd0);
      q_exp_adj = q_top ? exp_ff : exp_ff - 10'd1;
      q_inc     = q_guard & (q_sticky | q_sig[0]);
      q_sum     = {1'b0, q_sig} + {24'd0, q_inc};
      if (q_sum[24]) begin
         q_mant = 24'h80_0000;
         q_exp  = q_exp_adj + 10'd1;
      end else begin
         q_mant = q_sum[23:0];
         q_exp  = q_exp_adj;
      end
      // The rounded quotient is q_mant * 2^(q_exp - 23). Shifting right by
      // 22 - q_exp leaves the integer part above the half bit.
      q_shift_w = 10'd22 - q_exp;
      q_shifted = q_mant >> q_shift_w[4:0];
      q_rnd     = {1'b0, q_shifted[8:1]} + {8'd0, q_shifted[0]};
      if ($signed(q_exp) >= 10'sd7) begin
         q_mag = i8q_pkg::CODE_LIMIT;
      end else if ($signed(q_exp) <= -10'sd2) begin
         q_mag = 8'd0;
      end else if (q_rnd > {1'b0, i8q_pkg::CODE_LIMIT}) begin
         q_mag = i8q_pkg::CODE_LIMIT;
      end else begin
         q_mag = q_rnd[7:0];
      end
      q_code = neg_ff ? 8'd0 - q_mag : q_mag;
   end

   always_comb begin
      state_in       = state_ff;
      max_in         = max_ff;
      scale_in       = scale_ff;
      scale_valid_in = scale_valid_ff;
      is_rep_in      = is_rep_ff;
      neg_in         = neg_ff;
      exp_in         = exp_ff;
      divisor_in     = divisor_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      pend_kind_in   = pend_kind_ff;
      pend_code_in   = pend_code_ff;
      pend_status_in = pend_status_ff;
      rsp_tvalid_in  = rsp_tvalid_ff & ~rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_scale_in   = rsp_scale_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cnt_in         = 5'd0;
               quo_in         = 26'd0;
               pend_code_in   = 8'd0;
               pend_status_in = i8q_pkg::STATUS_OK;
               unique case (i8q_pkg::mode_type'(req_tuser))
                  i8q_pkg::MODE_CLEAR: begin
                     max_in = i8q_pkg::MAX_RESET_BITS;
                  end
                  i8q_pkg::MODE_MEASURE: begin
                     // Non-negative floats order like their bit patterns.
                     if (!in_nan && in_mag > max_ff) begin
                        max_in = in_mag;
                     end
                  end
                  i8q_pkg::MODE_REPORT: begin
                     pend_kind_in = i8q_pkg::KIND_SCALE;
                     is_rep_in    = 1'b1;
                     neg_in       = 1'b0;
                     if (max_ff == i8q_pkg::POS_INF_BITS) begin
                        scale_in       = i8q_pkg::POS_INF_BITS;
                        scale_valid_in = 1'b1;
                        state_in       = ST_OUT;
                     end else begin
                        rem_in     = {2'b01, max_ff[22:0]};
                        divisor_in = i8q_pkg::DIV127_MANT;
                        exp_in     = {2'b00, max_ff[30:23]}
                                     - {2'b00, i8q_pkg::DIV127_EXP}
                                     + {2'b00, i8q_pkg::EXP_BIAS};
                        state_in   = ST_DIV;
                     end
                  end
                  i8q_pkg::MODE_QUANTIZE: begin
                     pend_kind_in = i8q_pkg::KIND_CODE;
                     is_rep_in    = 1'b0;
                     neg_in       = req_tdata[31];
                     state_in     = ST_OUT;
                     if (!scale_valid_ff) begin
                        pend_status_in = i8q_pkg::STATUS_NO_SCALE;
                     end else if (in_nan || scale_ff[30:23] == 8'hFF) begin
                        pend_code_in = 8'd0;
                     end else if (in_inf || $signed(exp_diff) >= 10'sd8) begin
                        pend_code_in = sat_code;
                     end else if (in_exp == 8'd0 || $signed(exp_diff) <= -10'sd3) begin
                        // Zero, subnormal or below a quarter rounds to zero.
                        pend_code_in = 8'd0;
                     end else begin
                        rem_in     = {2'b01, req_tdata[22:0]};
                        divisor_in = {1'b1, scale_ff[22:0]};
                        exp_in     = exp_diff;
                        state_in   = ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[24:0], div_ge};
            rem_in = div_ge ? {div_sub[23:0], 1'b0} : {rem_ff[23:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(i8q_pkg::DIV_STEPS - 1)) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            if (is_rep_ff) begin
               scale_in       = {1'b0, q_exp[7:0], q_mant[22:0]};
               scale_valid_in = 1'b1;
            end else begin
               pend_code_in = q_code;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_scale_in  = scale_ff;
               rsp_code_in   = pend_code_ff;
               rsp_status_in = pend_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_ff         <= i8q_pkg::MAX_RESET_BITS;
         scale_ff       <= 32'd0;
         scale_valid_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         max_ff         <= max_in;
         scale_ff       <= scale_in;
         scale_valid_ff <= scale_valid_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
      is_rep_ff      <= is_rep_in;
      neg_ff         <= neg_in;
      exp_ff         <= exp_in;
      divisor_ff     <= divisor_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      cnt_ff         <= cnt_in;
      pend_kind_ff   <= pend_kind_in;
      pend_code_ff   <= pend_code_in;
      pend_status_ff <= pend_status_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_scale_ff   <= rsp_scale_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_code_ff, rsp_scale_ff};

`ifndef SYNTH
   // Once a scale has been reported it stays latched.
   a_scale_kept: assert property (@(posedge clock) disable iff (reset)
      scale_valid_ff |=> scale_valid_ff)
      else $error("latched scale was lost");

   // The running maximum is a magnitude and never NaN.
   a_max_mag: assert property (@(posedge clock) disable iff (reset)
      max_ff <= i8q_pkg::POS_INF_BITS)
      else $error("running maximum is not a valid magnitude");

   // Codes stay within -127 to 127.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_code_ff != 8'h80)
      else $error("code outside the symmetric range");

   // The no-scale status only comes with a zero code result.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_status_ff |-> rsp_kind_ff == i8q_pkg::KIND_CODE
                                         && rsp_code_ff == 8'd0)
      else $error("error status on a malformed result");

   // The divider never runs past its step count.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < 5'(i8q_pkg::DIV_STEPS))
      else $error("divider step count overran");
`endif

endmodule

// ----- tb/int8_absmax_quantizer_checker.sv -----
// ----------------------------------------------------------------------------
// int8_absmax_quantizer_checker: result predictor and scoreboard
// Watches both channels of the quantizer, predicts each result word with a
// bit-exact single-precision model of its own and compares field by field.
// ----------------------------------------------------------------------------
module int8_absmax_quantizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending_count
);

   localparam logic [31:0] F127_BITS = 32'h42FE_0000;

   typedef struct packed {
      i8q_pkg::kind_type   kind;
      logic [31:0]         scale_bits;
      logic [7:0]          code;
      i8q_pkg::status_type status;
   } quant_result_type;

   quant_result_type result_queue[$];
   logic [31:0]      peak_bits;
   logic [31:0]      scale_bits;
   logic             scale_set;

   // Single division a / b, round to nearest even. The divisor is a positive
   // normal number; the dividend is any finite value.
   function automatic logic [31:0] single_divide(logic [31:0] a, logic [31:0] b);
      logic [23:0]     ma;
      logic [23:0]     mb;
      int              ea;
      int              ex;
      int              sh;
      int              lower;
      longint unsigned num;
      longint unsigned quo;
      longint unsigned r;
      longint unsigned bits;
      logic            sticky;
      logic            rnd;
      if (a[30:0] == 31'd0)
         return {a[31] ^ b[31], 31'd0};
      if (a[30:23] == 8'd0) begin
         ma = {1'b0, a[22:0]};
         ea = 1;
         while (!ma[23]) begin
            ma = ma << 1;
            ea--;
         end
      end else begin
         ma = {1'b1, a[22:0]};
         ea = a[30:23];
      end
      mb = {1'b1, b[22:0]};
      sh = (ma < mb) ? 1 : 0;
      ex = ea - int'(b[30:23]) + 127 - sh;
      num = longint'(ma) << (25 + sh);
      quo = num / mb;
      sticky = (num % mb) != 0;
      // Quotient has 26 bits: 24 significand bits, a guard bit, one more.
      r = (quo << 1) | sticky;
      if (ex < 1) begin
         lower = 1 - ex;
         if (lower > 40)
            lower = 40;
         sticky = (r & ((64'd1 << lower) - 1)) != 0;
         r = (r >> lower) | sticky;
      end
      rnd = r[2] & (r[1] | r[0] | r[3]);
      bits = ((ex < 1) ? 64'd0 : (longint'(ex - 1) << 23)) + (r >> 3) + rnd;
      if (bits >= 64'h7F80_0000)
         bits = 64'h7F80_0000;
      return {a[31] ^ b[31], bits[30:0]};
   endfunction

   // Round half away from zero, saturating at +/-127.
   function automatic logic [7:0] code_of(logic [31:0] q);
      int          e;
      int          n;
      logic [23:0] m;
      if (q[30:0] >= 31'h42FE_0000)
         return q[31] ? -8'sd127 : 8'sd127;
      e = q[30:23];
      if (e < 126)
         return 8'd0;
      m = {1'b1, q[22:0]};
      n = m >> (150 - e);
      n += m[149 - e];
      if (n > 127)
         n = 127;
      return q[31] ? 8'(-n) : 8'(n);
   endfunction

   always @(posedge clock) begin
      quant_result_type want;
      quant_result_type got;
      if (reset) begin
         peak_bits     <= i8q_pkg::MAX_RESET_BITS;
         scale_bits    <= 32'd0;
         scale_set     <= 1'b0;
         fail_count    <= 0;
         pending_count <= 0;
         result_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = i8q_pkg::kind_type'(rsp_tuser);
            got.scale_bits = rsp_tdata[31:0];
            got.code       = rsp_tdata[39:32];
            got.status     = i8q_pkg::status_type'(rsp_tdata[40]);
            if (result_queue.size() == 0) begin
               $error("result word with nothing expected: %h %b", rsp_tdata, rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = result_queue.pop_front();
               if (got != want)
                  fail_count <= fail_count + 1;
               if (got.kind != want.kind)
                  $error("kind: expected %0d, actual %0d", want.kind, got.kind);
               if (got.scale_bits != want.scale_bits)
                  $error("scale_bits: expected %h, actual %h",
                         want.scale_bits, got.scale_bits);
               if (got.code != want.code)
                  $error("code: expected %0d, actual %0d",
                         $signed(want.code), $signed(got.code));
               if (got.status != want.status)
                  $error("status: expected %0d, actual %0d", want.status, got.status);
            end
         end
         if (req_tvalid && req_tready) begin
            case (i8q_pkg::mode_type'(req_tuser))
               i8q_pkg::MODE_CLEAR: begin
                  peak_bits <= i8q_pkg::MAX_RESET_BITS;
               end
               i8q_pkg::MODE_MEASURE: begin
                  // Both magnitudes are non-negative, so the bit patterns order
                  // the same way as the values.
                  if ({1'b0, req_tdata[30:0]} > peak_bits)
                     peak_bits <= {1'b0, req_tdata[30:0]};
               end
               i8q_pkg::MODE_REPORT: begin
                  want.kind       = i8q_pkg::KIND_SCALE;
                  want.scale_bits = single_divide(peak_bits, F127_BITS);
                  want.code       = 8'd0;
                  want.status     = i8q_pkg::STATUS_OK;
                  scale_bits <= want.scale_bits;
                  scale_set  <= 1'b1;
                  result_queue.insert(result_queue.size(), want);
               end
               default: begin
                  want.kind       = i8q_pkg::KIND_CODE;
                  want.scale_bits = scale_bits;
                  if (scale_set) begin
                     want.code   = code_of(single_divide(req_tdata, scale_bits));
                     want.status = i8q_pkg::STATUS_OK;
                  end else begin
                     want.code   = 8'd0;
                     want.status = i8q_pkg::STATUS_NO_SCALE;
                  end
                  result_queue.insert(result_queue.size(), want);
               end
            endcase
         end
         pending_count <= result_queue.size();
      end
   end

endmodule

// ----- tb/int8_absmax_quantizer_test.sv -----
// ----------------------------------------------------------------------------
// int8_absmax_quantizer_test: top of the quantizer testbench
// Drives directed and random word sequences into the quantizer with random
// idling and back-pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module int8_absmax_quantizer_test;

   localparam int ITEM_TARGET = 1850;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] value
   logic [1:0]  req_tuser;    // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [31:0] scale_bits, [39:32] code, [40] status
   logic        rsp_tuser;    // [0] kind
   int          fail_count;
   int          pending_count;
   int          cycle_count;
   int          words_sent;

   int8_absmax_quantizer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   int8_absmax_quantizer_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Free-running cycle count; both sides use it to agree on the window in
   // which nobody idles, without racing on a shared flag.
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
      end
   end

   function automatic logic quiet_window();
      return cycle_count >= 8000 && cycle_count < 14000;
   endfunction

   // Builds a finite single with the given biased exponent (clamped so that
   // no infinity or NaN is produced) and random sign and mantissa.
   function automatic logic [31:0] finite_value(int expo);
      if (expo < 0)
         expo = 0;
      if (expo > 254)
         expo = 254;
      return {1'($urandom_range(1, 0)), 8'(expo), 23'($urandom)};
   endfunction

   // Offers one word and waits until the block takes it. Idle cycles are
   // inserted ahead of the word at random, outside the quiet window.
   task automatic send_word(i8q_pkg::mode_type mode, logic [31:0] value);
      while (!quiet_window() && $urandom_range(99, 0) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do
         @(posedge clock);
      while (!req_tready);
      words_sent++;
   endtask

   // Receiver: random stalls, except in the quiet window, plus one long
   // hold-off while the sender keeps offering words so the block backs up.
   initial begin
      int hold;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (cycle_count == 3000) begin
            for (hold = 0; hold < 400; hold++) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= quiet_window() || ($urandom_range(99, 0) >= 14);
         @(posedge clock);
      end
   end

   initial begin
      int peak_expo;
      int n;
      int k;
      bit drained;
      drained    = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = 32'd0;
      req_tuser  = i8q_pkg::MODE_CLEAR;
      reset      = 1'b1;
      words_sent = 0;
      repeat (7)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: quantize with no scale yet, the reset maximum, signed
      // zeros, the smallest subnormal, the largest finite magnitudes, codes
      // that saturate either way, and a clear that keeps the latched scale.
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h3F80_0000);
      send_word(i8q_pkg::MODE_REPORT,   32'hFFFF_FFFF);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h0000_0000);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h3089_705F);
      send_word(i8q_pkg::MODE_CLEAR,    32'hFFFF_FFFF);
      send_word(i8q_pkg::MODE_MEASURE,  32'h8000_0000);
      send_word(i8q_pkg::MODE_MEASURE,  32'h0000_0001);
      send_word(i8q_pkg::MODE_REPORT,   32'h0000_0000);
      send_word(i8q_pkg::MODE_MEASURE,  32'h7F7F_FFFF);
      send_word(i8q_pkg::MODE_MEASURE,  32'hFF7F_FFFF);
      send_word(i8q_pkg::MODE_REPORT,   32'h0000_0000);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h7F7F_FFFF);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'hFF7F_FFFF);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h0000_0001);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h8000_0000);
      send_word(i8q_pkg::MODE_CLEAR,    32'h0000_0000);
      send_word(i8q_pkg::MODE_MEASURE,  32'hBF80_0000);
      send_word(i8q_pkg::MODE_REPORT,   32'h0000_0000);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h3F80_0000);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'hBF80_0000);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h3C01_0204);
      send_word(i8q_pkg::MODE_CLEAR,    32'h0000_0000);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h3F00_0000);
      send_word(i8q_pkg::MODE_QUANTIZE, 32'h7F00_0000);

      // Random part: mostly well-formed passes (clear, measure a tensor,
      // report, quantize values around the same magnitude), with noise words
      // and fully random episodes mixed in.
      while (words_sent < ITEM_TARGET) begin
         if (!drained && words_sent >= 1200) begin
            // The sender rests once until every pending result has drained.
            drained = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0 || rsp_tvalid)
               @(posedge clock);
         end
         if ($urandom_range(99, 0) < 80) begin
            peak_expo = $urandom_range(250, 4);
            send_word(i8q_pkg::MODE_CLEAR, $urandom);
            n = $urandom_range(8, 1);
            for (k = 0; k < n; k++)
               send_word(i8q_pkg::MODE_MEASURE,
                         finite_value(peak_expo - $urandom_range(3, 0)));
            send_word(i8q_pkg::MODE_REPORT, $urandom);
            n = $urandom_range(30, 5);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(99, 0) < 15)
                  send_word(i8q_pkg::mode_type'($urandom_range(3, 0)),
                            finite_value($urandom_range(254, 0)));
               else
                  send_word(i8q_pkg::MODE_QUANTIZE,
                            finite_value(peak_expo - $urandom_range(10, 0)));
            end
         end else begin
            n = $urandom_range(10, 1);
            for (k = 0; k < n; k++)
               send_word(i8q_pkg::mode_type'($urandom_range(3, 0)),
                         finite_value($urandom_range(254, 0)));
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0 || rsp_tvalid)
         @(posedge clock);
      repeat (40)
         @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake: the slowest correct run is far shorter.
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
